@@ hw/rtl/scrp_pkg.sv @@
package scrp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned CNT_W   = 2;

    // Component IDs that the parser knows.
    localparam logic [BYTE_W-1:0] ID_HEADING     = 8'd5;
    localparam logic [BYTE_W-1:0] ID_TEMPERATURE = 8'd7;
    localparam logic [BYTE_W-1:0] ID_DISTORTION  = 8'd8;
    localparam logic [BYTE_W-1:0] ID_CALSTATUS   = 8'd9;
    localparam logic [BYTE_W-1:0] ID_ACCEL_X     = 8'd21;
    localparam logic [BYTE_W-1:0] ID_ACCEL_Z     = 8'd23;
    localparam logic [BYTE_W-1:0] ID_PITCH       = 8'd24;
    localparam logic [BYTE_W-1:0] ID_ROLL        = 8'd25;
    localparam logic [BYTE_W-1:0] ID_MAG_X       = 8'd27;
    localparam logic [BYTE_W-1:0] ID_MAG_Z       = 8'd29;
    localparam logic [BYTE_W-1:0] ID_GYRO_X      = 8'd74;
    localparam logic [BYTE_W-1:0] ID_GYRO_Z      = 8'd76;
    localparam logic [BYTE_W-1:0] ID_QUATERNION  = 8'd77;
    localparam logic [BYTE_W-1:0] ID_HEAD_STATUS = 8'd79;

    localparam logic [CNT_W-1:0] LAST_BYTE = 2'd3;
    localparam logic [IDX_W-1:0] LAST_ELEM = 2'd3;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_FLOAT,
        KIND_BYTE,
        KIND_FLAG,
        KIND_QUAT
    } kind_t;

    typedef struct packed {
        logic               valid;
        logic [BYTE_W-1:0]  component_id;
        logic [IDX_W-1:0]   element_index;
        logic [VALUE_W-1:0] value_bits;
        logic               is_byte_value;
    } result_t;

    function automatic kind_t id_kind(input logic [BYTE_W-1:0] id);
        kind_t k;
        k = KIND_NONE;
        if (id == ID_HEADING || id == ID_TEMPERATURE || id == ID_PITCH || id == ID_ROLL)
            k = KIND_FLOAT;
        else if ((id >= ID_ACCEL_X && id <= ID_ACCEL_Z) ||
                 (id >= ID_MAG_X && id <= ID_MAG_Z) ||
                 (id >= ID_GYRO_X && id <= ID_GYRO_Z))
            k = KIND_FLOAT;
        else if (id == ID_QUATERNION)
            k = KIND_QUAT;
        else if (id == ID_HEAD_STATUS)
            k = KIND_BYTE;
        else if (id == ID_DISTORTION || id == ID_CALSTATUS)
            k = KIND_FLAG;
        return k;
    endfunction

endpackage

@@ hw/rtl/sensor_component_record_parser.sv @@
// Sensor component record parser.
// The slave stream carries one payload byte per transaction in s_tdata, with
// s_tlast marking the last byte of a packet. Each record is an ID byte and
// a payload whose length the ID sets; unknown IDs are skipped.
// The master stream carries one decoded value per transaction: ID, element
// index and 32-bit value in m_tdata, and in m_tuser a flag that the value is
// a one-byte status or flag rather than float bits.
// A value passes the input register, then the result register, on its way
// to m_tvalid after the transaction that carries its last byte.
// Throughput: one byte per cycle, sustained, with m_tready held high. The
// parse between the two registers is combinational and sets this figure.
// Bytes that complete no value produce no master transaction.
// Reset clears the valid flags of both registers and returns the parser to waiting for an ID.
// When the receiver stalls, the result register holds its transaction and
// one more byte waits in the input register; s_tready then drops until the
// result is taken.
module sensor_component_record_parser
    import scrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // packet_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] component_id, [9:8] element_index,
                                   // [41:10] value_bits, [47:42] zero
    output logic        m_tuser    // [0] is_byte_value
);

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic              consume;
    result_t           res;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;

    // The byte in the input register is parsed once the result register is free.
    assign consume  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || consume;

    assign in_valid_next  = (s_tvalid && s_tready) || (in_valid_reg && !consume);
    assign out_valid_next = (consume && res.valid) || (out_valid_reg && !m_tready);

    scrp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (consume),
        .data_byte  (in_byte_reg),
        .packet_end (in_last_reg),
        .result     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (consume && res.valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.value_bits, out_reg.element_index, out_reg.component_id};
    assign m_tuser  = out_reg.is_byte_value;

    a_free_out_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled while the result register is empty");

    a_index_only_quat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.element_index != '0 |->
            out_reg.component_id == ID_QUATERNION)
        else $error("nonzero element index on a non-quaternion component");

    a_byte_value_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.is_byte_value |->
            out_reg.value_bits[VALUE_W-1:BYTE_W] == '0)
        else $error("byte value wider than one byte");

    a_flag_is_bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.component_id == ID_DISTORTION ||
                          out_reg.component_id == ID_CALSTATUS) |->
            out_reg.is_byte_value && out_reg.value_bits[VALUE_W-1:1] == '0)
        else $error("flag component not reduced to one bit");

endmodule

@@ hw/rtl/scrp_core.sv @@
module scrp_core
    import scrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              packet_end,
    output result_t           result
);

    logic               awaiting_reg, awaiting_next;
    logic [BYTE_W-1:0]  id_reg, id_next;
    logic [CNT_W-1:0]   bcnt_reg, bcnt_next;
    logic [IDX_W-1:0]   ecnt_reg, ecnt_next;
    logic [VALUE_W-1:0] shift_reg, shift_next;
    logic [VALUE_W-1:0] shifted;
    kind_t              cur_kind;

    assign cur_kind = id_kind(id_reg);
    assign shifted  = {shift_reg[VALUE_W-BYTE_W-1:0], data_byte};

    always_comb
    begin
        awaiting_next = awaiting_reg;
        id_next       = id_reg;
        bcnt_next     = bcnt_reg;
        ecnt_next     = ecnt_reg;
        shift_next    = shift_reg;
        result        = '0;
        result.component_id = id_reg;

        if (awaiting_reg)
        begin
            if (id_kind(data_byte) != KIND_NONE)
            begin
                id_next       = data_byte;
                awaiting_next = 1'b0;
                bcnt_next     = '0;
                ecnt_next     = '0;
                shift_next    = '0;
            end
        end
        else
        begin
            case (cur_kind)
                KIND_BYTE:
                begin
                    result.valid         = 1'b1;
                    result.value_bits    = {{(VALUE_W-BYTE_W){1'b0}}, data_byte};
                    result.is_byte_value = 1'b1;
                    awaiting_next        = 1'b1;
                end
                KIND_FLAG:
                begin
                    result.valid         = 1'b1;
                    result.value_bits    = {{(VALUE_W-1){1'b0}}, (data_byte != '0)};
                    result.is_byte_value = 1'b1;
                    awaiting_next        = 1'b1;
                end
                KIND_FLOAT, KIND_QUAT:
                begin
                    shift_next = shifted;
                    if (bcnt_reg == LAST_BYTE)
                    begin
                        result.valid         = 1'b1;
                        result.value_bits    = shifted;
                        result.element_index = (cur_kind == KIND_QUAT) ? ecnt_reg : '0;
                        bcnt_next            = '0;
                        shift_next           = '0;
                        if (cur_kind == KIND_QUAT && ecnt_reg != LAST_ELEM)
                            ecnt_next = ecnt_reg + 1'b1;
                        else
                            awaiting_next = 1'b1;
                    end
                    else
                    begin
                        bcnt_next = bcnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    awaiting_next = 1'b1;
                end
            endcase
        end

        // A packet end drops any partial value and waits for a new ID.
        if (packet_end)
        begin
            awaiting_next = 1'b1;
            bcnt_next     = '0;
            ecnt_next     = '0;
            shift_next    = '0;
        end

        if (!step)
            result.valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b1;
            id_reg       <= '0;
            bcnt_reg     <= '0;
            ecnt_reg     <= '0;
            shift_reg    <= '0;
        end
        else if (step)
        begin
            awaiting_reg <= awaiting_next;
            id_reg       <= id_next;
            bcnt_reg     <= bcnt_next;
            ecnt_reg     <= ecnt_next;
            shift_reg    <= shift_next;
        end
    end

endmodule
